// File: design/sprx_pkg.sv
// Shared types and codes for the serial port register block.
`default_nettype none
package sprx_pkg;

    // Transaction modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_BREAK = 2'd3;

    // Register selects
    localparam logic [2:0] SEL_CTRLA    = 3'd0;
    localparam logic [2:0] SEL_CTRLB    = 3'd1;
    localparam logic [2:0] SEL_INTENCLR = 3'd2;
    localparam logic [2:0] SEL_INTENSET = 3'd3;
    localparam logic [2:0] SEL_DATA     = 3'd4;
    localparam logic [2:0] SEL_STATUS   = 3'd5;
    localparam logic [2:0] SEL_INTFLAG  = 3'd6;
    localparam logic [2:0] SEL_WORD     = 3'd7;

    // Port kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_UART = 2'd1;
    localparam logic [1:0] KIND_SPI  = 2'd2;

    // Interrupt flag bits
    localparam logic [7:0] FLAG_DRE   = 8'h01;
    localparam logic [7:0] FLAG_TXC   = 8'h02;
    localparam logic [7:0] FLAG_RXC   = 8'h04;
    localparam logic [7:0] FLAG_ERROR = 8'h80;
    localparam logic [7:0] IRQ_MASK   = 8'hBF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  reg_sel;
        logic [3:0]  word_index;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
        logic [7:0]  spi_reply;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
        logic [4:0]  rx_space;
        logic        rx_dropped;
    } t_out;

endpackage
`default_nettype wire

// File: design/sprx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sprx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/serial_port_regs_with_rx_fifo_unit.sv
// Serial port register block with receive FIFO: top level.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+---------
//   in      | input     | i_in_valid / o_in_stall     | i_in  (t_in)
//   out     | output    | o_out_valid / i_out_stall   | o_out (t_out)
//
// One transaction per cycle unless an output stall holds it. Control registers
// and both memories (word file, receive store) are updated at the accepting
// edge; the memory read data is there in the cycle after acceptance, in the
// work stage, whose result is then registered at o_out_valid/o_out.
// Synchronous reset clears all control state and the word file valid bits at
// once; no clearing pass.
// An output stall backs up through the work stage to o_in_stall.
`default_nettype none
module serial_port_regs_with_rx_fifo_unit
    import sprx_pkg::*;
#(
    parameter int RX_DEPTH  = 16,
    parameter int REG_WORDS = 16
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_in   i_in,
    output logic  o_out_valid,
    input  wire   i_out_stall,
    output t_out  o_out
);

    localparam int HW   = $clog2(RX_DEPTH);
    localparam int CW   = $clog2(RX_DEPTH + 1);
    localparam int SumW = CW + 1;
    localparam int SpW  = (CW > 5) ? CW : 5;
    localparam int WA   = $clog2(REG_WORDS);

    localparam logic [1:0] SRC_IMM  = 2'd0;
    localparam logic [1:0] SRC_WORD = 2'd1;
    localparam logic [1:0] SRC_RX   = 2'd2;

    // architectural state
    logic [7:0]           r_int_en,  n_int_en;
    logic [7:0]           r_flags,   n_flags;
    logic [15:0]          r_status,  n_status;
    logic [15:0]          r_latch,   n_latch;
    logic [HW-1:0]        r_head,    n_head;
    logic [CW-1:0]        r_count,   n_count;
    logic                 r_rx_on,   n_rx_on;
    logic [1:0]           r_kind,    n_kind;
    logic [REG_WORDS-1:0] r_wf_vld,  n_wf_vld;

    // work stage and output register
    logic                 r_s1_vld;
    logic [1:0]           r_s1_src;
    logic                 r_s1_hit;
    t_out                 r_s1_res;
    logic                 r_out_vld;
    t_out                 r_out;

    logic                 accept;
    logic                 s2_free;
    logic                 s1_move;

    logic                 wf_we, wf_re;
    logic [WA-1:0]        wf_waddr, wf_raddr;
    logic [31:0]          wf_rdata;
    logic                 rx_we, rx_re;
    logic [HW-1:0]        rx_waddr;
    logic [7:0]           rx_rdata;
    logic [SumW-1:0]      tail_sum;
    logic                 rx_full;
    logic                 idx_ok;
    logic [SpW-1:0]       space_w;

    logic [1:0]           s1_src;
    logic [31:0]          imm;
    logic                 txv;
    logic [7:0]           txb;
    logic                 drop;
    t_out                 s1_res;
    t_out                 s1_out;

    assign s2_free    = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && s2_free;
    assign o_in_stall = r_s1_vld && !s2_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign tail_sum = (SumW'(r_head) + SumW'(r_count) >= SumW'(RX_DEPTH))
                    ? SumW'(r_head) + SumW'(r_count) - SumW'(RX_DEPTH)
                    : SumW'(r_head) + SumW'(r_count);
    assign rx_waddr = tail_sum[HW-1:0];
    assign rx_full  = (r_count == CW'(RX_DEPTH));
    assign idx_ok   = (int'(i_in.word_index) < REG_WORDS);

    always_comb begin
        n_int_en = r_int_en;
        n_flags  = r_flags;
        n_status = r_status;
        n_latch  = r_latch;
        n_head   = r_head;
        n_count  = r_count;
        n_rx_on  = r_rx_on;
        n_kind   = r_kind;
        n_wf_vld = r_wf_vld;
        wf_we    = 1'b0;
        wf_re    = 1'b0;
        wf_waddr = '0;
        wf_raddr = '0;
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        s1_src   = SRC_IMM;
        imm      = '0;
        txv      = 1'b0;
        txb      = '0;
        drop     = 1'b0;
        if (accept) begin
            case (i_in.mode)
                MODE_READ: begin
                    case (i_in.reg_sel)
                        SEL_CTRLA: begin
                            wf_re    = 1'b1;
                            wf_raddr = '0;
                            s1_src   = SRC_WORD;
                        end
                        SEL_CTRLB: begin
                            wf_re    = 1'b1;
                            wf_raddr = WA'(1);
                            s1_src   = SRC_WORD;
                        end
                        SEL_INTENCLR, SEL_INTENSET: imm = {24'd0, r_int_en};
                        SEL_DATA: begin
                            if (r_kind == KIND_UART) begin
                                if (r_count != '0) begin
                                    rx_re  = 1'b1;
                                    s1_src = SRC_RX;
                                    // pop only with receive enabled
                                    if (r_rx_on) begin
                                        n_head  = (r_head == HW'(RX_DEPTH - 1))
                                                ? '0 : r_head + 1'b1;
                                        n_count = r_count - 1'b1;
                                        if (r_count != CW'(1)) begin
                                            n_flags = r_flags | FLAG_RXC;
                                        end else begin
                                            n_flags = r_flags & ~FLAG_RXC;
                                        end
                                    end
                                end
                            end else if (r_kind == KIND_SPI) begin
                                imm = {24'd0, r_latch[7:0]};
                            end
                        end
                        SEL_STATUS:  imm = {16'd0, r_status};
                        SEL_INTFLAG: imm = {24'd0, r_flags};
                        default: begin
                            if (idx_ok) begin
                                wf_re    = 1'b1;
                                wf_raddr = WA'(i_in.word_index);
                                s1_src   = SRC_WORD;
                            end
                        end
                    endcase
                end
                MODE_WRITE: begin
                    case (i_in.reg_sel)
                        SEL_CTRLA: begin
                            if (i_in.write_data[0]) begin
                                // soft reset: everything but the interrupt enables
                                n_flags  = '0;
                                n_status = '0;
                                n_latch  = '0;
                                n_head   = '0;
                                n_count  = '0;
                                n_rx_on  = 1'b0;
                                n_kind   = KIND_NONE;
                                n_wf_vld = '0;
                            end else begin
                                if (i_in.write_data[4:3] == 2'b00) begin
                                    n_kind  = KIND_UART;
                                    n_flags = r_flags | FLAG_DRE | FLAG_TXC;
                                end else if (i_in.write_data[4] == 1'b0) begin
                                    n_kind  = KIND_SPI;
                                    n_flags = r_flags | FLAG_DRE | FLAG_TXC;
                                end else begin
                                    n_kind  = KIND_NONE;
                                end
                                wf_we       = 1'b1;
                                wf_waddr    = '0;
                                n_wf_vld[0] = 1'b1;
                            end
                        end
                        SEL_CTRLB: begin
                            n_rx_on     = i_in.write_data[17];
                            wf_we       = 1'b1;
                            wf_waddr    = WA'(1);
                            n_wf_vld[1] = 1'b1;
                        end
                        SEL_INTENCLR: n_int_en = r_int_en & ~i_in.write_data[7:0];
                        SEL_INTENSET: n_int_en = r_int_en | i_in.write_data[7:0];
                        SEL_DATA: begin
                            if (r_kind == KIND_UART) begin
                                txv     = 1'b1;
                                txb     = i_in.write_data[7:0];
                                n_flags = r_flags | FLAG_DRE | FLAG_TXC;
                                n_latch = '0;
                            end else if (r_kind == KIND_SPI) begin
                                txv     = 1'b1;
                                txb     = i_in.write_data[7:0];
                                n_latch = {8'd0, i_in.spi_reply};
                                n_flags = r_flags | FLAG_DRE | FLAG_TXC | FLAG_RXC;
                            end
                        end
                        SEL_STATUS:  n_status = i_in.write_data[15:0];
                        SEL_INTFLAG: n_flags  = i_in.write_data[7:0];
                        default: begin
                            if (idx_ok) begin
                                wf_we              = 1'b1;
                                wf_waddr           = WA'(i_in.word_index);
                                n_wf_vld[wf_waddr] = 1'b1;
                            end
                        end
                    endcase
                end
                MODE_RX: begin
                    if (rx_full) begin
                        drop = 1'b1;
                    end else begin
                        rx_we   = 1'b1;
                        n_count = r_count + 1'b1;
                        n_flags = r_flags | FLAG_RXC;
                    end
                end
                default: n_flags = r_flags | FLAG_ERROR;
            endcase
        end
    end

    assign space_w = SpW'(RX_DEPTH) - SpW'(n_count);

    always_comb begin
        s1_res            = '0;
        s1_res.read_data  = imm;
        s1_res.tx_valid   = txv;
        s1_res.tx_byte    = txb;
        s1_res.irq        = |(n_flags & n_int_en & IRQ_MASK);
        s1_res.rx_space   = n_rx_on ? space_w[4:0] : 5'd0;
        s1_res.rx_dropped = drop;
    end

    sprx_ram #(
        .WIDTH (32),
        .DEPTH (REG_WORDS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (wf_we),
        .i_waddr (wf_waddr),
        .i_wdata (i_in.write_data),
        .i_re    (wf_re),
        .i_raddr (wf_raddr),
        .o_rdata (wf_rdata)
    );

    sprx_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_in.rx_byte),
        .i_re    (rx_re),
        .i_raddr (r_head),
        .o_rdata (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_en <= '0;
            r_flags  <= '0;
            r_status <= '0;
            r_latch  <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_rx_on  <= 1'b0;
            r_kind   <= KIND_NONE;
            r_wf_vld <= '0;
        end else begin
            r_int_en <= n_int_en;
            r_flags  <= n_flags;
            r_status <= n_status;
            r_latch  <= n_latch;
            r_head   <= n_head;
            r_count  <= n_count;
            r_rx_on  <= n_rx_on;
            r_kind   <= n_kind;
            r_wf_vld <= n_wf_vld;
        end
    end

    // work stage: hold while the output register is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src <= s1_src;
            r_s1_hit <= r_wf_vld[wf_raddr];
            r_s1_res <= s1_res;
        end
    end

    always_comb begin
        s1_out = r_s1_res;
        case (r_s1_src)
            SRC_WORD: s1_out.read_data = r_s1_hit ? wf_rdata : 32'd0;
            SRC_RX:   s1_out.read_data = {24'd0, rx_rdata};
            default:  s1_out.read_data = r_s1_res.read_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= s1_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RX_DEPTH))
        else $error("receive count beyond depth");

    a_drop_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.rx_dropped) |-> (o_out.rx_space == 5'd0))
        else $error("dropped byte with free space reported");

    a_tx_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.tx_valid) |-> (o_out.read_data == 32'd0))
        else $error("send transaction carries read data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted transaction lost in work stage");

endmodule
`default_nettype wire

// File: tb/tb_serial_port_regs_with_rx_fifo_unit.sv
// Self-checking testbench for the serial port register block with receive FIFO.
`timescale 1ns / 100ps
module tb_serial_port_regs_with_rx_fifo_unit;
    import sprx_pkg::*;

    localparam int FIFO_DEPTH  = 16;
    localparam int NUM_WORDS   = 16;
    localparam int RAND_ITEMS  = 1550;
    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_TICKS = 8;

    typedef struct {
        t_in  item;
        int   reps;
        bit   typed;
        t_out typed_res;
    } t_row;

    logic clk;
    logic rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    // Shadow copy of the block state
    logic [31:0] sh_words [NUM_WORDS];
    logic [7:0]  sh_fifo [FIFO_DEPTH];
    logic [7:0]  sh_inten;
    logic [7:0]  sh_flags;
    logic [15:0] sh_status;
    logic [15:0] sh_latch;
    logic [3:0]  sh_head;
    logic [4:0]  sh_count;
    logic        sh_rx_on;
    logic        sh_tx_on;
    logic [1:0]  sh_kind;

    t_out exp_q[$];
    t_row row_list[$];

    int  err_count;
    int  sent_count;
    int  got_count;
    int  mode_count [4];
    int  drop_count;
    int  tx_count;
    int  irq_count;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  long_hold_req;

    serial_port_regs_with_rx_fifo_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 clk = ~clk;

    task automatic clear_shadow(input bit keep_enables);
        for (int k = 0; k < NUM_WORDS; k++) sh_words[k] = '0;
        for (int k = 0; k < FIFO_DEPTH; k++) sh_fifo[k] = '0;
        if (!keep_enables) sh_inten = '0;
        sh_flags  = '0;
        sh_status = '0;
        sh_latch  = '0;
        sh_head   = '0;
        sh_count  = '0;
        sh_rx_on  = 1'b0;
        sh_tx_on  = 1'b0;
        sh_kind   = KIND_NONE;
    endtask

    // Advance the shadow state by one transaction and return the result it causes
    task automatic predict_port(input t_in it, output t_out res);
        logic [2:0] fmode;
        res = '0;
        case (it.mode)
            MODE_READ: begin
                case (it.reg_sel)
                    SEL_CTRLA:    res.read_data = sh_words[0];
                    SEL_CTRLB:    res.read_data = sh_words[1];
                    SEL_INTENCLR,
                    SEL_INTENSET: res.read_data = {24'd0, sh_inten};
                    SEL_DATA: begin
                        if (sh_kind == KIND_UART) begin
                            if (sh_count != 0) begin
                                res.read_data = {24'd0, sh_fifo[sh_head]};
                                if (sh_rx_on) begin
                                    sh_head  = sh_head + 4'd1;
                                    sh_count = sh_count - 5'd1;
                                    if (sh_count != 0) sh_flags = sh_flags | FLAG_RXC;
                                    else sh_flags = sh_flags & ~FLAG_RXC;
                                end
                            end
                        end else if (sh_kind == KIND_SPI) begin
                            res.read_data = {24'd0, sh_latch[7:0]};
                        end
                    end
                    SEL_STATUS:   res.read_data = {16'd0, sh_status};
                    SEL_INTFLAG:  res.read_data = {24'd0, sh_flags};
                    default:      res.read_data = sh_words[it.word_index];
                endcase
            end
            MODE_WRITE: begin
                case (it.reg_sel)
                    SEL_CTRLA: begin
                        if (it.write_data[0]) begin
                            clear_shadow(1'b1);
                        end else begin
                            fmode = it.write_data[4:2];
                            if (fmode <= 3'd1) begin
                                sh_kind  = KIND_UART;
                                sh_flags = sh_flags | FLAG_DRE | FLAG_TXC;
                            end else if (fmode <= 3'd3) begin
                                sh_kind  = KIND_SPI;
                                sh_flags = sh_flags | FLAG_DRE | FLAG_TXC;
                            end else begin
                                sh_kind = KIND_NONE;
                            end
                            sh_words[0] = it.write_data;
                        end
                    end
                    SEL_CTRLB: begin
                        sh_tx_on    = it.write_data[16];
                        sh_rx_on    = it.write_data[17];
                        sh_words[1] = it.write_data;
                    end
                    SEL_INTENCLR: sh_inten = sh_inten & ~it.write_data[7:0];
                    SEL_INTENSET: sh_inten = sh_inten | it.write_data[7:0];
                    SEL_DATA: begin
                        if (sh_kind == KIND_UART) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = it.write_data[7:0];
                            sh_flags     = sh_flags | FLAG_DRE | FLAG_TXC;
                            sh_latch     = '0;
                        end else if (sh_kind == KIND_SPI) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = it.write_data[7:0];
                            sh_latch     = {8'd0, it.spi_reply};
                            sh_flags     = sh_flags | FLAG_DRE | FLAG_TXC | FLAG_RXC;
                        end
                    end
                    SEL_STATUS:  sh_status = it.write_data[15:0];
                    SEL_INTFLAG: sh_flags  = it.write_data[7:0];
                    default:     sh_words[it.word_index] = it.write_data;
                endcase
            end
            MODE_RX: begin
                if (sh_count >= FIFO_DEPTH) begin
                    res.rx_dropped = 1'b1;
                end else begin
                    sh_fifo[sh_head + sh_count[3:0]] = it.rx_byte;
                    sh_count = sh_count + 5'd1;
                    sh_flags = sh_flags | FLAG_RXC;
                end
            end
            default: sh_flags = sh_flags | FLAG_ERROR;
        endcase
        res.rx_space = sh_rx_on ? 5'(FIFO_DEPTH - sh_count) : 5'd0;
        res.irq      = |(sh_flags & sh_inten & IRQ_MASK);
    endtask

    task automatic add_row(input logic [1:0] m, input logic [2:0] sel, input logic [3:0] idx,
                           input logic [31:0] wd, input logic [7:0] rxb,
                           input logic [7:0] reply, input int reps, input bit typed,
                           input logic [31:0] exp_rd, input logic exp_irq);
        t_row r;
        r.item.mode       = m;
        r.item.reg_sel    = sel;
        r.item.word_index = idx;
        r.item.write_data = wd;
        r.item.rx_byte    = rxb;
        r.item.spi_reply  = reply;
        r.reps            = reps;
        r.typed           = typed;
        r.typed_res           = '0;
        r.typed_res.read_data = exp_rd;
        r.typed_res.irq       = exp_irq;
        row_list.push_back(r);
    endtask

    // bias: 0 mixed traffic, 1 receive burst, 2 data read burst
    function automatic t_in random_op(input int bias);
        t_in it;
        int  pick;
        it.mode       = MODE_READ;
        it.reg_sel    = 3'($urandom_range(0, 7));
        it.word_index = 4'($urandom_range(0, 15));
        it.write_data = $urandom;
        it.rx_byte    = 8'($urandom_range(0, 255));
        it.spi_reply  = 8'($urandom_range(0, 255));
        pick = (bias == 1) ? 0 : (bias == 2) ? 30 : $urandom_range(0, 99);
        if (pick < 28) begin
            it.mode = MODE_RX;
        end else if (pick < 50) begin
            it.reg_sel = SEL_DATA;
        end else if (pick < 60) begin
            it.mode    = MODE_WRITE;
            it.reg_sel = SEL_DATA;
        end else if (pick < 63) begin
            it.mode = MODE_BREAK;
        end else if (pick < 68) begin
            it.mode             = MODE_WRITE;
            it.reg_sel          = SEL_CTRLB;
            it.write_data[17]   = ($urandom_range(0, 4) != 0);
        end else if (pick < 72) begin
            it.mode    = MODE_WRITE;
            it.reg_sel = SEL_CTRLA;
            it.write_data[0] = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) != 0) it.write_data[4:2] = 3'($urandom_range(0, 3));
        end else if (pick < 80) begin
            it.mode = MODE_WRITE;
            if (it.reg_sel inside {SEL_CTRLA, SEL_CTRLB, SEL_DATA}) it.reg_sel = SEL_WORD;
        end
        return it;
    endfunction

    // Offer one transaction, hold it until accepted, then record what it should produce
    task automatic offer_item(input t_in it, input bit typed, input t_out typed_res);
        int   gap;
        t_out pred;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        predict_port(it, pred);
        exp_q.push_back(typed ? typed_res : pred);
        sent_count++;
        mode_count[it.mode]++;
        if (sent_count % 100 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // Result checker
    always @(posedge clk) begin
        t_out want;
        if (rst_n && o_out_valid && !i_out_stall) begin
            got_count++;
            if (exp_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: unexpected result %h at %0t", o_out, $time);
            end else begin
                want = exp_q.pop_front();
                drop_count += want.rx_dropped;
                tx_count   += want.tx_valid;
                irq_count  += want.irq;
                if (o_out.read_data !== want.read_data || o_out.tx_valid !== want.tx_valid ||
                    o_out.tx_byte !== want.tx_byte || o_out.irq !== want.irq ||
                    o_out.rx_space !== want.rx_space ||
                    o_out.rx_dropped !== want.rx_dropped) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: result %0d: rd %h/%h txv %b/%b txb %h/%h irq %b/%b space %0d/%0d drop %b/%b (exp/got)",
                                 got_count, want.read_data, o_out.read_data,
                                 want.tx_valid, o_out.tx_valid, want.tx_byte, o_out.tx_byte,
                                 want.irq, o_out.irq, want.rx_space, o_out.rx_space,
                                 want.rx_dropped, o_out.rx_dropped);
                end
            end
        end
    end

    // Output side: stall before each result for a random hold, or for LONG_HOLD on request
    initial begin
        int hold;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                hold = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                i_out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!o_out_valid) @(posedge clk);
            if (got_count % 100 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int   n;
        int   bias;
        int   run;
        bit   pressed;
        t_out none;
        clk           = 1'b0;
        rst_n         = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_stall   = 1'b0;
        err_count     = 0;
        sent_count    = 0;
        got_count     = 0;
        drop_count    = 0;
        tx_count      = 0;
        irq_count     = 0;
        mode_count    = '{default: 0};
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        long_hold_req = 1'b0;
        pressed       = 1'b0;
        none          = '0;
        clear_shadow(1'b0);

        // Directed table: values typed in only where they follow from reset state
        add_row(MODE_READ,  SEL_CTRLA,    4'd0,  32'h0,        8'h00, 8'h00, 1, 1, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_INTFLAG,  4'd0,  32'h0,        8'h00, 8'h00, 1, 1, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_DATA,     4'd0,  32'hFFFFFFFF, 8'h00, 8'hFF, 1, 1, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_DATA,     4'd0,  32'h0,        8'h00, 8'h00, 1, 1, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_WORD,     4'd15, 32'hFFFFFFFF, 8'h00, 8'h00, 1, 1, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_WORD,     4'd15, 32'h0,        8'h00, 8'h00, 1, 1,
                32'hFFFFFFFF, 1'b0);
        add_row(MODE_WRITE, SEL_INTENSET, 4'd0,  32'h000000FF, 8'h00, 8'h00, 1, 1, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_INTENCLR, 4'd0,  32'h0,        8'h00, 8'h00, 1, 1, 32'hFF, 1'b0);
        add_row(MODE_BREAK, SEL_CTRLA,    4'd0,  32'h0,        8'h00, 8'h00, 1, 1, 32'h0, 1'b1);
        add_row(MODE_WRITE, SEL_INTFLAG,  4'd0,  32'h0,        8'h00, 8'h00, 1, 1, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_CTRLA,    4'd0,  32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_CTRLB,    4'd0,  32'h00030000, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_RX,    SEL_CTRLA,    4'd0,  32'h0,        8'hA5, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_DATA,     4'd0,  32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        // fill the FIFO and push one byte past full
        add_row(MODE_RX,    SEL_CTRLA,    4'd0,  32'h0,        8'hFF, 8'h00, 17, 0, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_DATA,     4'd0,  32'h0,        8'h00, 8'h00, 2, 0, 32'h0, 1'b0);
        // receive off: head byte is read without popping
        add_row(MODE_WRITE, SEL_CTRLB,    4'd0,  32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_DATA,     4'd0,  32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_DATA,     4'd0,  32'hFFFFFF00, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_CTRLA,    4'd0,  32'h00000008, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_DATA,     4'd0,  32'h00000055, 8'h00, 8'hFF, 1, 0, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_DATA,     4'd0,  32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_CTRLA,    4'd0,  32'h00000010, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_STATUS,   4'd0,  32'hFFFFFFFF, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_STATUS,   4'd0,  32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_WRITE, SEL_INTENCLR, 4'd0,  32'h000000F0, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        // soft reset keeps the interrupt enables, clears the rest
        add_row(MODE_WRITE, SEL_CTRLA,    4'd0,  32'hFFFFFFFF, 8'h00, 8'h00, 1, 0, 32'h0, 1'b0);
        add_row(MODE_READ,  SEL_WORD,     4'd15, 32'h0,        8'h00, 8'h00, 1, 0, 32'h0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (row_list[r]) begin
            for (int k = 0; k < row_list[r].reps; k++)
                offer_item(row_list[r].item, row_list[r].typed, row_list[r].typed_res);
        end

        n = 0;
        while (n < RAND_ITEMS) begin
            bias = 0;
            run  = 1;
            if ($urandom_range(0, 19) == 0) begin
                bias = $urandom_range(1, 2);
                run  = 20;
            end
            for (int k = 0; k < run; k++) begin
                // halfway through, hold off the output for a long stretch
                if (!pressed && n >= RAND_ITEMS / 2) begin
                    long_hold_req = 1'b1;
                    pressed       = 1'b1;
                end
                offer_item(random_op(bias), 1'b0, none);
                n++;
            end
        end
        i_in_valid <= 1'b0;

        while (exp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        $display("Covered %0d transactions: %0d reads, %0d writes, %0d received bytes, %0d breaks",
                 sent_count, mode_count[MODE_READ], mode_count[MODE_WRITE],
                 mode_count[MODE_RX], mode_count[MODE_BREAK]);
        $display("Saw %0d bytes sent, %0d bytes dropped at full FIFO, %0d results with irq, %0d errors",
                 tx_count, drop_count, irq_count, err_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/sprx_pkg.sv
design/sprx_ram.sv
design/serial_port_regs_with_rx_fifo_unit.sv
tb/tb_serial_port_regs_with_rx_fifo_unit.sv
